>>> rtl/dlc_pkg.sv
package dlc_pkg;

   // fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 5;
   localparam int TAPS_W   = 6;
   localparam int OUT_W    = 37;
   localparam int PROD_W   = 2 * SAMPLE_W;

   // command codes carried in the cmd field
   localparam logic OP_COEF   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // tap count after reset
   localparam logic [TAPS_W-1:0] TAP_COUNT_RESET = 6'd32;

   // input item as it arrives
   typedef struct packed {
      logic                       cmd;
      logic [INDEX_W-1:0]         coef_index;
      logic signed [SAMPLE_W-1:0] value;
      logic                       last_in;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [OUT_W-1:0] sample_out;
      logic                    last_out;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic                       op;
      logic [INDEX_W-1:0]         index;
      logic signed [SAMPLE_W-1:0] value;
      logic                       last;
   } cmd_type;

endpackage

>>> rtl/direct_linear_convolution.sv
// channel   ports                           handshake
// input     push, full, req_data            taken when push and not full
// result    empty, pop, rsp_data            taken when pop and not empty
// control   csr_we, csr_wdata               tap count written when csr_we
//
// a coefficient item is written to the coefficient table in the back end
// a sample item and each tail output are computed by
// the single multiply-accumulate that walks one tap per cycle
// reset clears the coefficient valid bits and delay line fill count at once
// a full result queue stalls the back end; the command queue absorbs input meanwhile
module direct_linear_convolution #(
   parameter int MAX_TAPS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  dlc_pkg::req_type           req_data,
   output logic                       empty,
   input  logic                       pop,
   output dlc_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [dlc_pkg::TAPS_W-1:0] csr_wdata
);

   logic [dlc_pkg::TAPS_W-1:0]      tap_count_ff, tap_count_in;
   logic                            cmd_empty;
   logic                            cmd_pop;
   dlc_pkg::cmd_type                cmd_data;
   logic                            res_full;
   logic                            res_push;
   dlc_pkg::rsp_type                res_data;
   logic [$bits(dlc_pkg::rsp_type)-1:0] rsp_raw;

   // tap count register
   assign tap_count_in = csr_we ? csr_wdata : tap_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= dlc_pkg::TAP_COUNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   // accept and classify
   dlc_front #(
      .MAX_TAPS (MAX_TAPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data)
   );

   // filter arithmetic
   dlc_back #(
      .MAX_TAPS (MAX_TAPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tap_count (tap_count_ff),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // result queue
   dlc_fifo #(
      .WIDTH ($bits(dlc_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_data),
      .full    (res_full),
      .pop     (pop),
      .rd_data (rsp_raw),
      .empty   (empty)
   );

   assign rsp_data = dlc_pkg::rsp_type'(rsp_raw);

endmodule

>>> rtl/dlc_fifo.sv
module dlc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   // status and head of queue
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/dlc_front.sv
module dlc_front #(
   parameter int MAX_TAPS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dlc_pkg::req_type req_data,
   input  logic             cmd_pop,
   output logic             cmd_empty,
   output dlc_pkg::cmd_type cmd_data
);

   dlc_pkg::cmd_type                cmd_wr;
   logic [$bits(dlc_pkg::cmd_type)-1:0] cmd_rd;
   logic                            accept;
   logic                            keep;

   // classify: samples always go on, coefficient writes only inside the table
   assign accept = push && !full;
   always_comb begin
      cmd_wr.op    = req_data.cmd;
      cmd_wr.index = req_data.coef_index;
      cmd_wr.value = req_data.value;
      cmd_wr.last  = req_data.last_in;
      keep = accept && ((req_data.cmd == dlc_pkg::OP_SAMPLE)
                        || (int'(req_data.coef_index) < MAX_TAPS));
   end

   // short command queue towards the back end
   dlc_fifo #(
      .WIDTH ($bits(dlc_pkg::cmd_type)),
      .DEPTH (4)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (keep),
      .wr_data (cmd_wr),
      .full    (full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   assign cmd_data = dlc_pkg::cmd_type'(cmd_rd);

endmodule

>>> rtl/dlc_back.sv
module dlc_back #(
   parameter int MAX_TAPS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [dlc_pkg::TAPS_W-1:0]     tap_count,
   input  logic                           cmd_empty,
   output logic                           cmd_pop,
   input  dlc_pkg::cmd_type               cmd_data,
   input  logic                           res_full,
   output logic                           res_push,
   output dlc_pkg::rsp_type               res_data
);

   localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TC_W  = $clog2(MAX_TAPS + 1);
   localparam int CMP_W = (TC_W > dlc_pkg::TAPS_W) ? TC_W : dlc_pkg::TAPS_W;
   localparam int SW    = dlc_pkg::SAMPLE_W;
   localparam int OW    = dlc_pkg::OUT_W;
   localparam int PW    = dlc_pkg::PROD_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   // sequencer state
   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [TC_W-1:0]     fill_ff, fill_in;
   logic [TC_W-1:0]     taps_ff, taps_in;
   logic [TC_W-1:0]     tail_ff, tail_in;
   logic                pend_last_ff, pend_last_in;
   logic [TC_W-1:0]     j_ff, j_in;
   logic [AW-1:0]       dptr_ff, dptr_in;
   logic [AW-1:0]       cptr_ff, cptr_in;
   logic [MAX_TAPS-1:0] coef_valid_ff, coef_valid_in;

   // multiply-accumulate pipeline
   logic                 rd_v_ff, rd_v_in;
   logic                 rd_dv_ff, rd_dv_in;
   logic signed [SW-1:0] coef_q_ff, dl_q_ff;
   logic                 coef_hit_ff;
   logic signed [PW-1:0] mul_ff, mul_in;
   logic                 mul_v_ff;
   logic signed [OW-1:0] acc_ff, acc_in;

   // coefficient table and circular delay line
   logic signed [SW-1:0] coef_mem [MAX_TAPS];
   logic signed [SW-1:0] dl_mem [MAX_TAPS];

   logic [CMP_W-1:0]     tc_ext;
   logic [TC_W-1:0]      act_taps;
   logic [TC_W-1:0]      start_taps;
   logic [AW-1:0]        head_next;
   logic                 coef_wr;
   logic                 dl_wr;
   logic signed [SW-1:0] dl_wdata;
   logic                 start;

   // taps in use: zero counts as one, anything above the table as the table
   always_comb begin
      tc_ext = CMP_W'(tap_count);
      if (tc_ext == '0) begin
         act_taps = TC_W'(1);
      end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
         act_taps = TC_W'(MAX_TAPS);
      end else begin
         act_taps = TC_W'(tc_ext);
      end
   end

   assign head_next = (head_ff == AW'(MAX_TAPS - 1)) ? '0 : head_ff + AW'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      taps_in       = taps_ff;
      tail_in       = tail_ff;
      pend_last_in  = pend_last_ff;
      j_in          = j_ff;
      dptr_in       = dptr_ff;
      cptr_in       = cptr_ff;
      coef_valid_in = coef_valid_ff;
      acc_in        = acc_ff;
      rd_v_in       = 1'b0;
      rd_dv_in      = 1'b0;
      cmd_pop       = 1'b0;
      res_push      = 1'b0;
      coef_wr       = 1'b0;
      dl_wr         = 1'b0;
      dl_wdata      = '0;
      start         = 1'b0;
      start_taps    = taps_ff;
      res_data.sample_out = acc_ff;
      res_data.last_out   = pend_last_ff && (tail_ff == '0);

      if (mul_v_ff) begin
         acc_in = acc_ff + OW'(mul_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_data.op == dlc_pkg::OP_COEF) begin
                  coef_wr = 1'b1;
                  coef_valid_in[AW'(cmd_data.index)] = 1'b1;
               end else begin
                  dl_wr        = 1'b1;
                  dl_wdata     = cmd_data.value;
                  taps_in      = act_taps;
                  pend_last_in = cmd_data.last;
                  tail_in      = cmd_data.last ? act_taps - TC_W'(1) : '0;
                  start        = 1'b1;
                  start_taps   = act_taps;
               end
            end
         end
         ST_RUN: begin
            rd_v_in  = 1'b1;
            rd_dv_in = (j_ff < fill_ff);
            dptr_in  = (dptr_ff == '0) ? AW'(MAX_TAPS - 1) : dptr_ff - AW'(1);
            cptr_in  = cptr_ff - AW'(1);
            j_in     = j_ff + TC_W'(1);
            if (j_ff == taps_ff - TC_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !mul_v_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!res_full) begin
               res_push = 1'b1;
               if (tail_ff != '0) begin
                  // flush a tail output: shift in a zero sample
                  tail_in = tail_ff - TC_W'(1);
                  dl_wr   = 1'b1;
                  start   = 1'b1;
               end else begin
                  if (pend_last_ff) begin
                     fill_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shift into the delay line
      if (dl_wr) begin
         head_in = head_next;
         fill_in = (fill_ff == TC_W'(MAX_TAPS)) ? fill_ff : fill_ff + TC_W'(1);
      end

      // begin a walk over the taps for a new output
      if (start) begin
         state_in = ST_RUN;
         dptr_in  = head_next;
         cptr_in  = AW'(start_taps - TC_W'(1));
         j_in     = '0;
         acc_in   = '0;
      end
   end

   // product of the read stage, zero for entries never written
   always_comb begin
      mul_in = coef_q_ff * dl_q_ff;
      if (!(rd_dv_ff && coef_hit_ff)) begin
         mul_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         fill_ff       <= '0;
         coef_valid_ff <= '0;
         rd_v_ff       <= 1'b0;
         mul_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         coef_valid_ff <= coef_valid_in;
         rd_v_ff       <= rd_v_in;
         mul_v_ff      <= rd_v_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      taps_ff      <= taps_in;
      tail_ff      <= tail_in;
      pend_last_ff <= pend_last_in;
      j_ff         <= j_in;
      dptr_ff      <= dptr_in;
      cptr_ff      <= cptr_in;
      rd_dv_ff     <= rd_dv_in;
      mul_ff       <= mul_in;
      acc_ff       <= acc_in;
      coef_hit_ff  <= coef_valid_ff[cptr_ff];
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (coef_wr) begin
         coef_mem[AW'(cmd_data.index)] <= cmd_data.value;
      end
      if (dl_wr) begin
         dl_mem[head_next] <= dl_wdata;
      end
      coef_q_ff <= coef_mem[cptr_ff];
      dl_q_ff   <= dl_mem[dptr_ff];
   end

   // checks
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_data.last_out) |=> (fill_ff == '0))
      else $error("delay line not cleared after final item");

   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!rd_v_ff && !mul_v_ff))
      else $error("result taken before accumulation finished");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (j_ff < taps_ff))
      else $error("tap walk ran past tap count");

   a_tail_restart: assert property (@(posedge clock) disable iff (reset)
      (res_push && (tail_ff != '0)) |=> ((state_ff == ST_RUN) && (acc_ff == '0)))
      else $error("tail output did not restart the walk");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= TC_W'(MAX_TAPS))
      else $error("delay line fill beyond depth");

endmodule
